### rtl/plm_pkg.sv
// Package for the positional list engine: operation and status codes,
// controller states, cell command struct and default sizes.
// No dependencies.
package plm_pkg;

    // Default sizes
    localparam int unsigned CAPACITY_DEFAULT   = 64;
    localparam int unsigned DATA_WIDTH_DEFAULT = 32;

    // Match bits examined per scan cycle
    localparam int unsigned GROUP_SIZE = 8;

    // Operation codes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_GET    = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;
    localparam logic [1:0] OP_SEARCH = 2'd3;

    // Status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_BAD  = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    // Register map: word index and reset value
    localparam logic       REG_COMPARE_MASK  = 1'b0;
    localparam logic [31:0] MASK_RESET       = 32'hFFFF_FFFF;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN
    } plm_state_t;

    // Command broadcast to every cell
    typedef struct packed {
        logic ins;   // insert: load at position, shift up above it
        logic rem;   // remove: shift down from position
    } plm_cmd_t;

    // Scanner status toward the controller
    typedef struct packed {
        logic hit;   // current group holds a match
        logic last;  // current group is the final one
    } plm_scan_stat_t;

endpackage

### rtl/plm_cell.sv
// One list cell: holds a single entry, shifts with its neighbors and
// compares its entry with the search key. Depends on plm_pkg.
module plm_cell #(
    parameter int unsigned INDEX      = 0,
    parameter int unsigned CNT_W      = 7,
    parameter int unsigned DATA_WIDTH = plm_pkg::DATA_WIDTH_DEFAULT
) (
    input  logic                  aclk,
    input  plm_pkg::plm_cmd_t     cmd,
    input  logic [CNT_W-1:0]      position,
    input  logic [CNT_W-1:0]      count,
    input  logic [DATA_WIDTH-1:0] value,
    input  logic [DATA_WIDTH-1:0] mask,
    input  logic [DATA_WIDTH-1:0] left_data,
    input  logic [DATA_WIDTH-1:0] right_data,
    output logic [DATA_WIDTH-1:0] data,
    output logic                  match
);

    localparam logic [CNT_W-1:0] IDX = CNT_W'(INDEX);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;

    always_comb begin
        data_next = data_reg;
        if (cmd.ins) begin
            if (IDX == position) begin
                data_next = value;
            end else if (IDX > position) begin
                data_next = left_data;
            end
        end else if (cmd.rem) begin
            if (IDX >= position) begin
                data_next = right_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data  = data_reg;
    assign match = (IDX < count) && (((data_reg ^ value) & mask) == '0);

endmodule

### rtl/plm_scan.sv
// First-match scanner: holds the registered match vector and walks it one
// group of bits per cycle while advance is high. Depends on plm_pkg.
module plm_scan #(
    parameter int unsigned CAPACITY = plm_pkg::CAPACITY_DEFAULT,
    parameter int unsigned IDX_W    = $clog2(CAPACITY)
) (
    input  logic                       aclk,
    input  logic                       start,
    input  logic                       advance,
    input  logic [CAPACITY-1:0]        match_vec,
    output plm_pkg::plm_scan_stat_t    stat,
    output logic [IDX_W-1:0]           found_index
);

    localparam int unsigned GS      = plm_pkg::GROUP_SIZE;
    localparam int unsigned NGROUPS = (CAPACITY + GS - 1) / GS;
    localparam int unsigned VEC_W   = NGROUPS * GS;
    localparam int unsigned GCNT_W  = $clog2(NGROUPS + 1);
    localparam int unsigned LOC_W   = $clog2(GS);

    logic [VEC_W-1:0]  vec_reg;
    logic [VEC_W-1:0]  vec_next;
    logic [GCNT_W-1:0] grp_reg;
    logic [GCNT_W-1:0] grp_next;
    logic [LOC_W-1:0]  local_idx;

    always_comb begin
        vec_next = vec_reg;
        grp_next = grp_reg;
        if (start) begin
            vec_next = VEC_W'(match_vec);
            grp_next = '0;
        end else if (advance) begin
            vec_next = vec_reg >> GS;
            grp_next = grp_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        vec_reg <= vec_next;
        grp_reg <= grp_next;
    end

    // lowest set bit of the current group
    always_comb begin
        local_idx = '0;
        for (int i = GS - 1; i >= 0; i--) begin
            if (vec_reg[i]) begin
                local_idx = LOC_W'(i);
            end
        end
    end

    assign stat.hit    = |vec_reg[GS-1:0];
    assign stat.last   = (grp_reg == GCNT_W'(NGROUPS - 1));
    assign found_index = IDX_W'({grp_reg, local_idx});

endmodule

### rtl/positional_list_engine.sv
// Top level of the positional list engine: controller, APB register,
// chain of list cells and first-match scanner.
// Depends on plm_pkg, plm_cell and plm_scan.
//
//  channel   direction  handshake            payload
//  s_        in         s_valid / s_ready    s_op, s_position, s_value
//  m_        out        m_valid / m_ready    m_status, m_read_value,
//                                            m_found_index, m_entry_count
//  apb       in/out     psel/penable/pready  paddr, pwdata, prdata
//
// Insert, get and remove: a word is accepted in S_IDLE; in S_EXEC the whole
// cell chain shifts at once and the result is registered.
// Search: every cell compares in parallel, then in S_SCAN the scanner walks
// the match bits 8 per cycle until a match or the last group.
// A new word is accepted while a result still waits on m_; a stall on m_
// holds the pending operation, and cells change only when its result is
// registered. Reset clears the count and the mask; cell contents stay
// undefined, which is harmless since only entries below the count are read.
module positional_list_engine #(
    parameter int unsigned CAPACITY   = plm_pkg::CAPACITY_DEFAULT,
    parameter int unsigned DATA_WIDTH = plm_pkg::DATA_WIDTH_DEFAULT,
    parameter int unsigned CNT_W      = $clog2(CAPACITY + 1),
    parameter int unsigned IDX_W      = $clog2(CAPACITY)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // input words
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_op,
    input  logic [CNT_W-1:0]      s_position,
    input  logic [DATA_WIDTH-1:0] s_value,
    // result words
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [1:0]            m_status,
    output logic [DATA_WIDTH-1:0] m_read_value,
    output logic [IDX_W-1:0]      m_found_index,
    output logic [CNT_W-1:0]      m_entry_count,
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    // ---------------------------------------------------------------
    // Configuration register
    // ---------------------------------------------------------------
    logic [31:0] mask_reg;
    logic [31:0] mask_next;

    always_comb begin
        mask_next = mask_reg;
        if (psel && penable && pwrite && (paddr[2] == plm_pkg::REG_COMPARE_MASK)) begin
            mask_next = pwdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg <= plm_pkg::MASK_RESET;
        end else begin
            mask_reg <= mask_next;
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == plm_pkg::REG_COMPARE_MASK) ? mask_reg : 32'd0;

    // ---------------------------------------------------------------
    // Controller registers
    // ---------------------------------------------------------------
    plm_pkg::plm_state_t   state_reg, state_next;
    logic [1:0]            op_reg, op_next;
    logic [CNT_W-1:0]      pos_reg, pos_next;
    logic [DATA_WIDTH-1:0] val_reg, val_next;
    logic [CNT_W-1:0]      count_reg, count_next;

    logic                  m_valid_reg, m_valid_next;
    logic [1:0]            status_reg, status_next;
    logic [DATA_WIDTH-1:0] rd_reg, rd_next;
    logic [IDX_W-1:0]      found_reg, found_next;
    logic [CNT_W-1:0]      cnt_out_reg, cnt_out_next;

    // chain and scanner signals
    plm_pkg::plm_cmd_t       cmd;
    plm_pkg::plm_scan_stat_t scan_stat;
    logic                    scan_start;
    logic                    scan_advance;
    logic [IDX_W-1:0]        scan_index;
    logic [CAPACITY-1:0]     match_vec;
    logic [DATA_WIDTH-1:0]   cell_data [CAPACITY];
    logic [DATA_WIDTH-1:0]   mask_ext;

    logic out_free;
    logic pos_in_range;   // position addresses a held entry
    logic ins_pos_ok;     // position at or below the count
    logic list_full;
    logic [1:0] exec_status;

    assign mask_ext     = DATA_WIDTH'(mask_reg);
    assign out_free     = !m_valid_reg || m_ready;
    assign pos_in_range = pos_reg < count_reg;
    assign ins_pos_ok   = pos_reg <= count_reg;
    assign list_full    = count_reg >= CNT_W'(CAPACITY);

    // status of insert, get and remove; the position check wins over full
    always_comb begin
        exec_status = plm_pkg::ST_OK;
        if (op_reg == plm_pkg::OP_INSERT) begin
            if (!ins_pos_ok) begin
                exec_status = plm_pkg::ST_BAD;
            end else if (list_full) begin
                exec_status = plm_pkg::ST_FULL;
            end
        end else if (!pos_in_range) begin
            exec_status = plm_pkg::ST_BAD;
        end
    end

    // ---------------------------------------------------------------
    // Next state and outputs
    // ---------------------------------------------------------------
    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        pos_next     = pos_reg;
        val_next     = val_reg;
        count_next   = count_reg;
        m_valid_next = m_valid_reg;
        status_next  = status_reg;
        rd_next      = rd_reg;
        found_next   = found_reg;
        cnt_out_next = cnt_out_reg;
        s_ready      = 1'b0;
        cmd          = '0;
        scan_start   = 1'b0;
        scan_advance = 1'b0;

        // drop the result once taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            plm_pkg::S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    op_next    = s_op;
                    pos_next   = s_position;
                    val_next   = s_value;
                    state_next = plm_pkg::S_EXEC;
                end
            end

            plm_pkg::S_EXEC: begin
                if (op_reg == plm_pkg::OP_SEARCH) begin
                    // capture every cell's compare, then walk the bits
                    scan_start = 1'b1;
                    state_next = plm_pkg::S_SCAN;
                end else if (out_free) begin
                    // commit: shift the chain and register the result
                    m_valid_next = 1'b1;
                    status_next  = exec_status;
                    found_next   = '0;
                    rd_next      = '0;
                    cnt_out_next = count_reg;
                    if (exec_status == plm_pkg::ST_OK) begin
                        if (op_reg == plm_pkg::OP_INSERT) begin
                            cmd.ins      = 1'b1;
                            count_next   = count_reg + 1'b1;
                            cnt_out_next = count_reg + 1'b1;
                        end else if (op_reg == plm_pkg::OP_REMOVE) begin
                            cmd.rem      = 1'b1;
                            count_next   = count_reg - 1'b1;
                            cnt_out_next = count_reg - 1'b1;
                        end else begin
                            rd_next = cell_data[pos_reg[IDX_W-1:0]];
                        end
                    end
                    state_next = plm_pkg::S_IDLE;
                end
            end

            plm_pkg::S_SCAN: begin
                if (scan_stat.hit || scan_stat.last) begin
                    // hold the scan until the output register frees up
                    if (out_free) begin
                        m_valid_next = 1'b1;
                        status_next  = scan_stat.hit ? plm_pkg::ST_OK : plm_pkg::ST_BAD;
                        found_next   = scan_stat.hit ? scan_index : '0;
                        rd_next      = '0;
                        cnt_out_next = count_reg;
                        state_next   = plm_pkg::S_IDLE;
                    end
                end else begin
                    scan_advance = 1'b1;
                end
            end

            default: begin
                state_next = plm_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= plm_pkg::S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers carry no reset
    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        pos_reg     <= pos_next;
        val_reg     <= val_next;
        status_reg  <= status_next;
        rd_reg      <= rd_next;
        found_reg   <= found_next;
        cnt_out_reg <= cnt_out_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = status_reg;
    assign m_read_value  = rd_reg;
    assign m_found_index = found_reg;
    assign m_entry_count = cnt_out_reg;

    // ---------------------------------------------------------------
    // Cell chain: each cell takes its left neighbor on insert and its
    // right neighbor on remove; the ends see zero.
    // ---------------------------------------------------------------
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [DATA_WIDTH-1:0] left_w;
        logic [DATA_WIDTH-1:0] right_w;

        if (g == 0) begin : g_first
            assign left_w = '0;
        end else begin : g_mid_l
            assign left_w = cell_data[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign right_w = '0;
        end else begin : g_mid_r
            assign right_w = cell_data[g+1];
        end

        plm_cell #(
            .INDEX      (g),
            .CNT_W      (CNT_W),
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .aclk       (aclk),
            .cmd        (cmd),
            .position   (pos_reg),
            .count      (count_reg),
            .value      (val_reg),
            .mask       (mask_ext),
            .left_data  (left_w),
            .right_data (right_w),
            .data       (cell_data[g]),
            .match      (match_vec[g])
        );
    end

    // ---------------------------------------------------------------
    // First-match scanner
    // ---------------------------------------------------------------
    plm_scan #(
        .CAPACITY (CAPACITY),
        .IDX_W    (IDX_W)
    ) u_scan (
        .aclk        (aclk),
        .start       (scan_start),
        .advance     (scan_advance),
        .match_vec   (match_vec),
        .stat        (scan_stat),
        .found_index (scan_index)
    );

endmodule

### tb/tb.sv
// Self-checking testbench for positional_list_engine: random and directed list
// operations, a tracking copy of the list, and APB writes of the compare mask.
// Depends on plm_pkg and the positional_list_engine RTL.

typedef struct {
    logic [1:0]  status;
    logic [31:0] read_value;
    logic [5:0]  found_index;
    logic [6:0]  entry_count;
} list_result_t;

class list_tracker;
    logic [31:0]  store [plm_pkg::CAPACITY_DEFAULT];
    int unsigned  held;
    logic [31:0]  mask;
    list_result_t pending_results [$];
    int unsigned  errors;

    function new();
        held   = 0;
        mask   = plm_pkg::MASK_RESET;
        errors = 0;
    endfunction

    // Apply one accepted word to the list copy and queue the result it must give.
    function void note_word(logic [1:0] op, logic [6:0] pos, logic [31:0] val);
        list_result_t r;
        int i;
        r = '{plm_pkg::ST_OK, 32'd0, 6'd0, 7'd0};
        case (op)
            plm_pkg::OP_INSERT: begin
                if (pos > held) begin
                    r.status = plm_pkg::ST_BAD;
                end else if (held >= plm_pkg::CAPACITY_DEFAULT) begin
                    r.status = plm_pkg::ST_FULL;
                end else begin
                    for (i = held; i > pos; i--)
                        store[i] = store[i-1];
                    store[pos] = val;
                    held++;
                end
            end
            plm_pkg::OP_GET: begin
                if (pos >= held)
                    r.status = plm_pkg::ST_BAD;
                else
                    r.read_value = store[pos];
            end
            plm_pkg::OP_REMOVE: begin
                if (pos >= held) begin
                    r.status = plm_pkg::ST_BAD;
                end else begin
                    for (i = pos; i + 1 < held; i++)
                        store[i] = store[i+1];
                    held--;
                end
            end
            default: begin
                // walk downward so the lowest matching index wins
                r.status = plm_pkg::ST_BAD;
                for (i = int'(held) - 1; i >= 0; i--) begin
                    if (((store[i] ^ val) & mask) == 32'd0) begin
                        r.status      = plm_pkg::ST_OK;
                        r.found_index = i[5:0];
                    end
                end
            end
        endcase
        r.entry_count = held[6:0];
        pending_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    function void check_result(logic [1:0] status, logic [31:0] read_value,
                               logic [5:0] found_index, logic [6:0] entry_count);
        list_result_t want;
        if (pending_results.size() == 0) begin
            $display("%0t: result with none expected, expected nothing, %s %0h count %0h",
                     $time, "actual status", status, entry_count);
            errors++;
            return;
        end
        want = pending_results.pop_front();
        compare_field("status", 32'(want.status), 32'(status));
        compare_field("read_value", want.read_value, read_value);
        compare_field("found_index", 32'(want.found_index), 32'(found_index));
        compare_field("entry_count", 32'(want.entry_count), 32'(entry_count));
    endfunction
endclass

module tb;
    localparam int STALL_LIMIT = 4000;

    logic        aclk;
    logic        aresetn       = 1'b0;
    logic        s_valid       = 1'b0;
    logic        s_ready;
    logic [1:0]  s_op          = plm_pkg::OP_GET;
    logic [6:0]  s_position    = 7'd0;
    logic [31:0] s_value       = 32'd0;
    logic        m_valid;
    logic        m_ready       = 1'b0;
    logic [1:0]  m_status;
    logic [31:0] m_read_value;
    logic [5:0]  m_found_index;
    logic [6:0]  m_entry_count;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [2:0]  paddr         = 3'd0;
    logic [31:0] pwdata        = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    list_tracker tracker = new();

    int          send_idle_pct = 25;
    int          recv_idle_pct = 62;
    int          idle_cycles   = 0;
    bit          growing       = 1'b1;
    logic [31:0] value_pool [8];

    positional_list_engine dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_op(s_op),
        .s_position(s_position), .s_value(s_value),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
        .m_read_value(m_read_value), .m_found_index(m_found_index),
        .m_entry_count(m_entry_count),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Stall the result side at the current rate.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Sample both channels with their pre-edge values: check results first, since
    // a result can never belong to the word accepted at the same edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready)
                tracker.check_result(m_status, m_read_value, m_found_index, m_entry_count);
            if (s_valid && s_ready)
                tracker.note_word(s_op, s_position, s_value);
        end
    end

    // Watchdog: give up when no word moves on either channel for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Offer one word, idling first at the sender's rate, and hold it until taken.
    task automatic send_word(logic [1:0] op, logic [6:0] pos, logic [31:0] val);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_op       <= op;
        s_position <= pos;
        s_value    <= val;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Drop valid and hold off until every outstanding result has come back.
    task automatic wait_for_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (tracker.pending_results.size() != 0)
            @(posedge aclk);
    endtask

    // Write the compare mask: setup cycle, then access cycle until pready.
    task automatic write_mask(logic [31:0] new_mask);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {plm_pkg::REG_COMPARE_MASK, 2'b00};
        pwdata  <= new_mask;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tracker.mask = new_mask;
    endtask

    function automatic logic [31:0] pick_value();
        if ($urandom_range(99) < 30)
            return value_pool[$urandom_range(7)];
        return $urandom;
    endfunction

    // Prefer keys that hit a held entry, with the unmasked bits scrambled.
    function automatic logic [31:0] pick_key();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 55 && tracker.held != 0)
            return tracker.store[$urandom_range(tracker.held - 1)]
                   ^ ($urandom & ~tracker.mask);
        if (roll < 70)
            return value_pool[$urandom_range(7)];
        return $urandom;
    endfunction

    // Swing the list between empty and full: grow until full (lingering there a
    // little so inserts see the full status), then shrink back toward empty.
    task automatic run_random(int items, bit pause_midway);
        int unsigned held;
        int unsigned roll;
        logic [1:0]  op;
        logic [6:0]  pos;
        for (int n = 0; n < items; n++) begin
            if (pause_midway && n == items / 2)
                wait_for_results();
            held = tracker.held;
            if (growing && held == plm_pkg::CAPACITY_DEFAULT && $urandom_range(3) == 0)
                growing = 1'b0;
            if (!growing && held <= 1)
                growing = 1'b1;
            roll = $urandom_range(99);
            if (growing)
                op = (roll < 55) ? plm_pkg::OP_INSERT : (roll < 70) ? plm_pkg::OP_GET :
                     (roll < 80) ? plm_pkg::OP_REMOVE : plm_pkg::OP_SEARCH;
            else
                op = (roll < 10) ? plm_pkg::OP_INSERT : (roll < 30) ? plm_pkg::OP_GET :
                     (roll < 80) ? plm_pkg::OP_REMOVE : plm_pkg::OP_SEARCH;
            if (op == plm_pkg::OP_SEARCH || $urandom_range(99) < 12)
                pos = 7'($urandom_range(127));
            else if (op == plm_pkg::OP_INSERT)
                pos = 7'($urandom_range(held));
            else
                pos = (held == 0) ? 7'd0 : 7'($urandom_range(held - 1));
            send_word(op, pos, (op == plm_pkg::OP_SEARCH) ? pick_key() : pick_value());
        end
    endtask

    function automatic logic [31:0] mask_for_segment(int seg);
        case (seg)
            0: return 32'hFFFF_FFFF;
            2: return 32'h0000_0000;
            3: return 32'h0000_FFFF;
            5: return 32'hFFFF_0000;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        value_pool[0] = 32'h0000_0000;
        value_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < 8; i++)
            value_pool[i] = $urandom;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        write_mask(32'hFFFF_FFFF);

        // Empty list: every access is out of range, and so is a far insert.
        send_word(plm_pkg::OP_GET,    7'd0,   32'd0);
        send_word(plm_pkg::OP_REMOVE, 7'd0,   32'd0);
        send_word(plm_pkg::OP_SEARCH, 7'd0,   32'd0);
        send_word(plm_pkg::OP_INSERT, 7'd1,   32'h1111_1111);
        send_word(plm_pkg::OP_INSERT, 7'd127, 32'h2222_2222);
        // Build [12345678, 00000000, A5A55A5A, FFFFFFFF]: append, middle, front.
        send_word(plm_pkg::OP_INSERT, 7'd0,   32'h0000_0000);
        send_word(plm_pkg::OP_INSERT, 7'd1,   32'hFFFF_FFFF);
        send_word(plm_pkg::OP_INSERT, 7'd1,   32'hA5A5_5A5A);
        send_word(plm_pkg::OP_INSERT, 7'd0,   32'h1234_5678);
        send_word(plm_pkg::OP_GET,    7'd0,   32'd0);
        send_word(plm_pkg::OP_GET,    7'd3,   32'd0);
        send_word(plm_pkg::OP_GET,    7'd4,   32'd0);
        send_word(plm_pkg::OP_GET,    7'd127, 32'd0);
        send_word(plm_pkg::OP_SEARCH, 7'd127, 32'hFFFF_FFFF);
        send_word(plm_pkg::OP_SEARCH, 7'd5,   32'h0000_0000);
        send_word(plm_pkg::OP_SEARCH, 7'd0,   32'hDEAD_BEEF);
        send_word(plm_pkg::OP_INSERT, 7'd6,   32'h3333_3333);
        send_word(plm_pkg::OP_REMOVE, 7'd4,   32'd0);
        send_word(plm_pkg::OP_REMOVE, 7'd3,   32'd0);
        send_word(plm_pkg::OP_REMOVE, 7'd0,   32'd0);
        send_word(plm_pkg::OP_REMOVE, 7'd1,   32'd0);
        send_word(plm_pkg::OP_GET,    7'd0,   32'd0);
        send_word(plm_pkg::OP_REMOVE, 7'd0,   32'd0);

        // Three idling modes, two mask settings each; the mask changes only
        // once the block has returned every result.
        for (int seg = 0; seg < 6; seg++) begin
            case (seg / 2)
                0: begin
                    send_idle_pct = 25;
                    recv_idle_pct = 62;
                end
                1: begin
                    send_idle_pct = 62;
                    recv_idle_pct = 25;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            wait_for_results();
            write_mask(mask_for_segment(seg));
            run_random(125, seg == 3);
        end

        wait_for_results();
        repeat (20) @(posedge aclk);
        if (tracker.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
